[hdl/byte_stack_with_search_core_macros.svh]
// ----------------------------------------------------------------------------
// byte_stack_with_search_core_macros.svh
// Assertion macros shared by the stack checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STACK_WITH_SEARCH_CORE_MACROS_SVH
`define BYTE_STACK_WITH_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Field widths, operation and status codes, and controller/datapath structs
// for the byte stack with search.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // read address sources
  localparam logic [1:0] RD_TOP   = 2'd0;
  localparam logic [1:0] RD_FIRST = 2'd1;
  localparam logic [1:0] RD_NEXT  = 2'd2;

  // result kinds
  localparam logic [2:0] RK_FULL     = 3'd0;
  localparam logic [2:0] RK_EMPTY    = 3'd1;
  localparam logic [2:0] RK_PUSH     = 3'd2;
  localparam logic [2:0] RK_READ     = 3'd3;
  localparam logic [2:0] RK_FOUND    = 3'd4;
  localparam logic [2:0] RK_NOTFOUND = 3'd5;

  typedef struct packed {
    logic       take;
    logic       wr_en;
    logic       fill_inc;
    logic       fill_dec;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       idx_clr;
    logic       idx_inc;
    logic       res_load;
    logic [2:0] res_kind;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic              full;
    logic              match;
    logic              scan_last;
    logic              out_free;
  } dp_sts_t;

endpackage

[hdl/bss_in_if.sv]
// ----------------------------------------------------------------------------
// bss_in_if
// Request channel: one stack operation per request.
// ----------------------------------------------------------------------------
interface bss_in_if;
  logic                         valid;
  logic                         ready;
  logic [bss_pkg::MODE_W-1:0]   mode;
  logic [bss_pkg::BYTE_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

[hdl/bss_out_if.sv]
// ----------------------------------------------------------------------------
// bss_out_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface bss_out_if;
  logic                           valid;
  logic                           ready;
  logic [bss_pkg::STATUS_W-1:0]   status;
  logic [bss_pkg::BYTE_W-1:0]     data;
  logic [bss_pkg::POS_W-1:0]      position;
  logic [bss_pkg::COUNT_W-1:0]    count;
  logic                           is_empty;

  modport source (output valid, output status, output data, output position,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input count, input is_empty, output ready);
endinterface

[hdl/bss_ctrl.sv]
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller: sequences one request at a time through execute, memory read,
// search scan and result hand-off.
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  bss_pkg::dp_sts_t   sts,
  output bss_pkg::ctl_cmd_t  cmd,
  output logic               in_ready
);
  import bss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sts.in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.mode)
          MODE_PUSH: begin
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
            if (sts.full) begin
              cmd.res_kind = RK_FULL;
            end else begin
              cmd.res_kind = RK_PUSH;
              cmd.wr_en    = 1'b1;
              cmd.fill_inc = 1'b1;
            end
          end
          MODE_POP, MODE_PEEK: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_EMPTY;
              state_next   = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_TOP;
              state_next = S_READ;
            end
          end
          default: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_EMPTY;
              state_next   = S_DONE;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_src  = RD_FIRST;
              cmd.idx_clr = 1'b1;
              state_next  = S_SCAN;
            end
          end
        endcase
      end
      S_READ: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_READ;
        cmd.fill_dec = (sts.mode == MODE_POP);
        state_next   = S_DONE;
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_FOUND;
          state_next   = S_DONE;
        end else if (sts.scan_last) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_NOTFOUND;
          state_next   = S_DONE;
        end else begin
          // advance to the next entry up
          cmd.idx_inc = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_src  = RD_NEXT;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/bss_dp.sv]
// ----------------------------------------------------------------------------
// bss_dp
// Datapath: entry memory with one registered read port, fill counter, scan
// index, result register and output register.
// ----------------------------------------------------------------------------
module bss_dp #(
  parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bss_pkg::ctl_cmd_t              cmd,
  output bss_pkg::dp_sts_t               sts,
  input  logic                           in_valid,
  input  logic [bss_pkg::MODE_W-1:0]     in_mode,
  input  logic [bss_pkg::BYTE_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bss_pkg::STATUS_W-1:0]   out_status,
  output logic [bss_pkg::BYTE_W-1:0]     out_data,
  output logic [bss_pkg::POS_W-1:0]      out_position,
  output logic [bss_pkg::COUNT_W-1:0]    out_count,
  output logic                           out_is_empty
);
  import bss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0]   mem [DEPTH];
  logic [BYTE_W-1:0]   rd_data;
  logic [AW-1:0]       rd_addr;

  logic [FW-1:0]       fill;
  logic [AW-1:0]       idx;
  logic [MODE_W-1:0]   op_mode;
  logic [BYTE_W-1:0]   op_value;

  logic [STATUS_W-1:0] res_status;
  logic [BYTE_W-1:0]   res_data;
  logic [AW-1:0]       res_pos;

  always_comb begin
    unique case (cmd.rd_src)
      RD_TOP:   rd_addr = AW'(fill - FW'(1));
      RD_FIRST: rd_addr = '0;
      RD_NEXT:  rd_addr = idx + AW'(1);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[fill[AW-1:0]] <= op_value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.fill_inc) begin
      fill <= fill + FW'(1);
    end else if (cmd.fill_dec) begin
      fill <= fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_mode  <= in_mode;
      op_value <= in_value;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= ST_OK;
      res_data   <= '0;
      res_pos    <= '0;
      unique case (cmd.res_kind)
        RK_FULL:     res_status <= ST_FULL;
        RK_EMPTY:    res_status <= ST_EMPTY;
        RK_PUSH:     res_data   <= op_value;
        RK_READ:     res_data   <= rd_data;
        RK_FOUND:    res_pos    <= idx;
        RK_NOTFOUND: res_status <= ST_NOTFOUND;
        default:     res_status <= ST_OK;
      endcase
    end
  end

  // output register; count reflects the fill after the operation
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= res_status;
      out_data     <= res_data;
      out_position <= POS_W'(res_pos);
      out_count    <= COUNT_W'(fill);
      out_is_empty <= (fill == '0);
    end
  end

  always_comb begin
    sts.in_valid  = in_valid;
    sts.mode      = op_mode;
    sts.empty     = (fill == '0);
    sts.full      = (fill == FW'(DEPTH));
    sts.match     = (rd_data == op_value);
    sts.scan_last = ((FW'(idx) + FW'(1)) == fill);
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

[hdl/byte_stack_with_search_core.sv]
// A byte-wide LIFO stack of DEPTH entries with a linear search from the
// bottom. Requests are handled one at a time; a result waits in an output
// register so the next request is taken while it is unread. A push (full or
// not) or a pop or peek on an empty stack passes through the execute and
// done states; a pop or peek that reads also passes through the read state,
// and a search steps through the scan state one entry at a time, stopping
// at the hit or, on a miss, after the top entry. The entry memory has a
// single registered read port serving every read, each scan step included.
// Storage comes up undefined and needs no clearing pass.
// ----------------------------------------------------------------------------
// byte_stack_with_search_core
// Top level: controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module byte_stack_with_search_core #(
  parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
  input logic     clk,
  input logic     rst,
  bss_in_if.sink  item,
  bss_out_if.source result
);
  import bss_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     in_ready;

  assign item.ready = in_ready;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  bss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_valid     (item.valid),
    .in_mode      (item.mode),
    .in_value     (item.value),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_status   (result.status),
    .out_data     (result.data),
    .out_position (result.position),
    .out_count    (result.count),
    .out_is_empty (result.is_empty)
  );

endmodule

[hdl/bss_checker.sv]
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks on the stack's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_stack_with_search_core_macros.svh"

module bss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bss_pkg::STATUS_W-1:0]   out_status,
  input logic [bss_pkg::BYTE_W-1:0]     out_data,
  input logic [bss_pkg::POS_W-1:0]      out_position,
  input logic [bss_pkg::COUNT_W-1:0]    out_count,
  input logic                           out_is_empty
);
  import bss_pkg::*;

  // hold a result until it is taken
  `BSS_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped")

  `BSS_ASSERT_NOW(a_empty_flag, out_valid && (out_count == '0), out_is_empty, "empty flag mismatch")

  `BSS_ASSERT_NOW(a_empty_result, out_valid && (out_status == ST_EMPTY), out_is_empty && (out_data == '0) && (out_position == '0), "bad empty result")

  `BSS_ASSERT_NOW(a_miss_result, out_valid && (out_status == ST_NOTFOUND), (out_data == '0) && (out_position == '0) && !out_is_empty, "bad miss result")

endmodule

bind byte_stack_with_search_core bss_checker u_bss_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_status   (result.status),
  .out_data     (result.data),
  .out_position (result.position),
  .out_count    (result.count),
  .out_is_empty (result.is_empty)
);
